/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; they compile away when
// the synthesis macro is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check on every clock edge outside reset
`define TSS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check on every clock edge, reset included
`define TSS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TSS_ASSERT(label, clk, rst, prop, msg)
`define TSS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

/* hdl/tss_pkg.sv */
// ----------------------------------------------------------------------------
// tss_pkg
// Shared widths, defaults, divider handshake types and output saturation.
// ----------------------------------------------------------------------------
`default_nettype none
package tss_pkg;

  localparam int XW  = 14;     // vertex x width
  localparam int YW  = 10;     // vertex y width
  localparam int RW  = 6;      // row field width
  localparam int SW  = 19;     // span x width
  localparam int DVW = 22;     // dividend magnitude width (|dx| * 256)
  localparam int QW  = 23;     // signed slope width
  localparam int AW  = 32;     // running edge accumulator width
  localparam int CW  = 11;     // scanline counter width

  localparam int TILE_ROWS_DEF     = 64;
  localparam int SUBPIXEL_BITS_DEF = 4;

  localparam logic signed [AW-1:0] SPAN_MAX = 32'sd262143;
  localparam logic signed [AW-1:0] SPAN_MIN = -32'sd262144;

  typedef struct packed {
    logic           start;
    logic [DVW-1:0] dividend;
    logic [YW-1:0]  divisor;
    logic           neg;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic                  busy;
    logic signed [QW-1:0]  quo;
  } div_rsp_t;

  // Clamp an accumulator to the span output range
  function automatic logic signed [SW-1:0] sat_span(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] c;
    c = v;
    if (v > SPAN_MAX) c = SPAN_MAX;
    if (v < SPAN_MIN) c = SPAN_MIN;
    return c[SW-1:0];
  endfunction

endpackage
`default_nettype wire

/* hdl/tss_ifs.sv */
// ----------------------------------------------------------------------------
// tss channel interfaces
// Triangle input channel and span output channel, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none
interface tss_tri_if;
  logic                      valid;
  logic                      ready;
  logic [tss_pkg::XW-1:0]    ax;
  logic [tss_pkg::YW-1:0]    ay;
  logic [tss_pkg::XW-1:0]    bx;
  logic [tss_pkg::YW-1:0]    by;
  logic [tss_pkg::XW-1:0]    cx;
  logic [tss_pkg::YW-1:0]    cy;
  modport source (output valid, ax, ay, bx, by, cx, cy, input ready);
  modport sink   (input valid, ax, ay, bx, by, cx, cy, output ready);
endinterface

interface tss_span_if;
  logic                          valid;
  logic                          ready;
  logic [tss_pkg::RW-1:0]        row;
  logic signed [tss_pkg::SW-1:0] span_x_first;
  logic signed [tss_pkg::SW-1:0] span_x_second;
  logic                          last_span;
  modport source (output valid, row, span_x_first, span_x_second, last_span, input ready);
  modport sink   (input valid, row, span_x_first, span_x_second, last_span, output ready);
endinterface
`default_nettype wire

/* hdl/tss_div.sv */
// ----------------------------------------------------------------------------
// tss_div
// Restoring divider, one quotient bit per cycle; sign applied at the end.
// ----------------------------------------------------------------------------
`default_nettype none
module tss_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tss_pkg::div_req_t req,
  output tss_pkg::div_rsp_t      rsp
);

  localparam int NSTEP = tss_pkg::DVW;
  localparam int CNW   = $clog2(NSTEP);

  logic [tss_pkg::YW-1:0]  rem;
  logic [tss_pkg::YW-1:0]  dvs;
  logic [tss_pkg::DVW-1:0] quo;
  logic [CNW-1:0]          cnt;
  logic                    busy;
  logic                    done;
  logic                    neg;

  logic [tss_pkg::YW:0]    trial;
  logic [tss_pkg::YW:0]    diff;
  logic                    take;

  // Shift in the next dividend bit and try the subtract
  always_comb begin
    trial = {rem, quo[tss_pkg::DVW-1]};
    diff  = trial - {1'b0, dvs};
    take  = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= req.dividend;
        dvs  <= req.divisor;
        neg  <= req.neg;
      end else if (busy) begin
        rem <= take ? diff[tss_pkg::YW-1:0] : trial[tss_pkg::YW-1:0];
        quo <= {quo[tss_pkg::DVW-2:0], take};
        cnt <= cnt + 1'b1;
        if (cnt == CNW'(NSTEP - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Apply sign to the magnitude quotient (truncation toward zero)
  always_comb begin
    rsp.done = done;
    rsp.busy = busy;
    rsp.quo  = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  end

endmodule
`default_nettype wire

/* hdl/triangle_scanline_spans_core.sv */
// Flow: after a triangle is accepted, three slope divisions run in turn on the one
// divider, then setup, then one span beat per cycle while the output is taken.
// A new triangle is accepted only in idle, once the walk of the previous one has
// issued its last span; the shared divider and the scanline walk both set the rate.
// Reset: synchronous active-high rst returns the sequencer to idle and empties
// the output register.
// ----------------------------------------------------------------------------
// triangle_scanline_spans_core
// Sorts vertices, divides out the slope of each edge on the single shared divider,
// then walks scanlines emitting a span beat for each row.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module triangle_scanline_spans_core #(
  parameter int TILE_ROWS     = tss_pkg::TILE_ROWS_DEF,
  parameter int SUBPIXEL_BITS = tss_pkg::SUBPIXEL_BITS_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  tss_tri_if.sink    tri_in,
  tss_span_if.source span_out
);

  localparam int XW = tss_pkg::XW;
  localparam int YW = tss_pkg::YW;
  localparam int CW = tss_pkg::CW;
  localparam int AW = tss_pkg::AW;
  localparam int QW = tss_pkg::QW;
  localparam int QSH = 8 - SUBPIXEL_BITS;
  localparam logic [CW-1:0] CEIL_ADD = CW'((1 << SUBPIXEL_BITS) - 1);
  localparam logic [CW-1:0] ROWS_L   = CW'(TILE_ROWS);

  typedef enum logic [3:0] {
    IDLE  = 4'b0001,
    DIV   = 4'b0010,
    SETUP = 4'b0100,
    WALK  = 4'b1000
  } state_t;

  state_t state;

  logic [XW-1:0] vx [3];
  logic [YW-1:0] vy [3];
  logic signed [QW-1:0] slope [3];
  logic [1:0]    idx;
  logic          div_start;
  logic [CW-1:0] y, ym, ye;
  logic signed [AW-1:0] cur1, cur2;

  tss_pkg::div_req_t dreq;
  tss_pkg::div_rsp_t drsp;

  // Sorted vertices at the input
  logic [XW-1:0] sx [3];
  logic [YW-1:0] sy [3];
  logic [XW-1:0] tx;
  logic [YW-1:0] ty;

  always_comb begin
    tx = '0;
    ty = '0;
    sx[0] = tri_in.ax; sy[0] = tri_in.ay;
    sx[1] = tri_in.bx; sy[1] = tri_in.by;
    sx[2] = tri_in.cx; sy[2] = tri_in.cy;
    if (sy[0] > sy[1]) begin
      tx = sx[0]; ty = sy[0]; sx[0] = sx[1]; sy[0] = sy[1]; sx[1] = tx; sy[1] = ty;
    end
    if (sy[0] > sy[2]) begin
      tx = sx[0]; ty = sy[0]; sx[0] = sx[2]; sy[0] = sy[2]; sx[2] = tx; sy[2] = ty;
    end
    if (sy[1] > sy[2]) begin
      tx = sx[1]; ty = sy[1]; sx[1] = sx[2]; sy[1] = sy[2]; sx[2] = tx; sy[2] = ty;
    end
  end

  // Pick the edge endpoints for the current division
  logic [XW-1:0] px, qx;
  logic [YW-1:0] py, qy;
  logic signed [XW:0] dx;
  logic [XW-1:0] dxm;
  logic [YW-1:0] dy;

  always_comb begin
    unique case (idx)
      2'd0:    begin px = vx[0]; py = vy[0]; qx = vx[1]; qy = vy[1]; end
      2'd1:    begin px = vx[0]; py = vy[0]; qx = vx[2]; qy = vy[2]; end
      default: begin px = vx[1]; py = vy[1]; qx = vx[2]; qy = vy[2]; end
    endcase
    dx  = $signed({1'b0, qx}) - $signed({1'b0, px});
    dxm = dx[XW] ? XW'(-dx) : dx[XW-1:0];
    dy  = qy - py;
    dreq.start    = div_start;
    dreq.dividend = {dxm, 8'd0};
    dreq.divisor  = dy;
    dreq.neg      = dx[XW];
  end

  tss_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  // Scanline bounds and start x from the sorted vertices
  logic [CW-1:0] y0_c, ym_c, ye_c;
  logic signed [AW-1:0] x1_q8, x2_q8;

  always_comb begin
    y0_c  = (CW'(vy[0]) + CEIL_ADD) >> SUBPIXEL_BITS;
    ym_c  = (CW'(vy[1]) + CEIL_ADD) >> SUBPIXEL_BITS;
    ye_c  = (CW'(vy[2]) + CEIL_ADD) >> SUBPIXEL_BITS;
    x1_q8 = AW'(vx[0]) << QSH;
    x2_q8 = AW'(vx[1]) << QSH;
  end

  // Walk step: short edge restarts at the middle vertex on its row
  logic step, last_now, upper;
  logic signed [AW-1:0] short_now, short_slope;
  logic [CW-1:0] y_inc;

  always_comb begin
    step        = (state == WALK) && (!span_out.valid || span_out.ready);
    upper       = (y < ym);
    short_now   = (y == ym) ? x2_q8 : cur1;
    short_slope = upper ? AW'(slope[0]) : AW'(slope[2]);
    y_inc       = y + 1'b1;
    last_now    = (y_inc == ye) || (y_inc == ROWS_L);
  end

  assign tri_in.ready = (state == IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= IDLE;
      div_start      <= 1'b0;
      idx            <= '0;
      span_out.valid <= 1'b0;
    end else begin
      div_start <= 1'b0;
      // Drop the beat once taken unless a new one replaces it
      if (span_out.valid && span_out.ready && !step) span_out.valid <= 1'b0;
      unique case (state)
        IDLE: begin
          if (tri_in.valid) begin
            for (int i = 0; i < 3; i++) begin
              vx[i] <= sx[i];
              vy[i] <= sy[i];
            end
            idx       <= '0;
            div_start <= 1'b1;
            state     <= DIV;
          end
        end
        DIV: begin
          // Store each slope; flat edges get zero
          if (drsp.done) begin
            slope[idx] <= (dy == '0) ? '0 : drsp.quo;
            if (idx == 2'd2) begin
              state <= SETUP;
            end else begin
              idx       <= idx + 1'b1;
              div_start <= 1'b1;
            end
          end
        end
        SETUP: begin
          y    <= y0_c;
          ym   <= ym_c;
          ye   <= ye_c;
          cur1 <= x1_q8;
          cur2 <= x1_q8;
          if (y0_c >= ye_c || y0_c >= ROWS_L) state <= IDLE;
          else                                state <= WALK;
        end
        WALK: begin
          // Emit one span beat and advance both edges
          if (step) begin
            span_out.valid         <= 1'b1;
            span_out.row           <= y[tss_pkg::RW-1:0];
            span_out.span_x_first  <= tss_pkg::sat_span(short_now);
            span_out.span_x_second <= tss_pkg::sat_span(cur2);
            span_out.last_span     <= last_now;
            cur1 <= short_now + short_slope;
            cur2 <= cur2 + AW'(slope[1]);
            y    <= y_inc;
            if (last_now) state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `TSS_ASSERT(a_ready_div_idle, clk, rst, tri_in.ready |-> !drsp.busy, "accept while dividing")
  `TSS_ASSERT(a_done_in_div, clk, rst, drsp.done |-> state == DIV, "divider done outside DIV")
  `TSS_ASSERT(a_last_ends, clk, rst, (step && last_now) |=> (state == IDLE), "walk not ended")
  `TSS_ASSERT(a_walk_rows, clk, rst, (state == WALK) |-> (y < ye && y < ROWS_L), "walk row")

endmodule
`default_nettype wire
